>>> design/vtir_pkg.sv
// ----------------------------------------------------------------------------
// vtir_pkg
// Shared types and constants for the VIA timer and interrupt register block.
// ----------------------------------------------------------------------------
package vtir_pkg;

  // Default timer prescale (ticks per timer step)
  localparam int TICK_DIVIDE_DEF = 8;

  localparam int TMR_W  = 16;
  localparam int FLAG_W = 7;

  // Request actions
  typedef logic [1:0] act_t;
  localparam act_t ACT_READ  = 2'd0;
  localparam act_t ACT_WRITE = 2'd1;
  localparam act_t ACT_TICK  = 2'd2;

  // Register map, standard adapter order
  typedef logic [3:0] reg_idx_t;
  localparam reg_idx_t REG_ORB    = 4'd0;
  localparam reg_idx_t REG_ORA    = 4'd1;
  localparam reg_idx_t REG_DDRB   = 4'd2;
  localparam reg_idx_t REG_DDRA   = 4'd3;
  localparam reg_idx_t REG_T1CL   = 4'd4;
  localparam reg_idx_t REG_T1CH   = 4'd5;
  localparam reg_idx_t REG_T1LL   = 4'd6;
  localparam reg_idx_t REG_T1LH   = 4'd7;
  localparam reg_idx_t REG_T2CL   = 4'd8;
  localparam reg_idx_t REG_T2CH   = 4'd9;
  localparam reg_idx_t REG_SR     = 4'd10;
  localparam reg_idx_t REG_ACR    = 4'd11;
  localparam reg_idx_t REG_PCR    = 4'd12;
  localparam reg_idx_t REG_IFR    = 4'd13;
  localparam reg_idx_t REG_IER    = 4'd14;
  localparam reg_idx_t REG_ORA_NH = 4'd15;

  // Interrupt flag bit positions
  localparam int FLAG_SR_BIT = 2;
  localparam int FLAG_T2_BIT = 5;
  localparam int FLAG_T1_BIT = 6;

  // ACR bit selecting timer 1 free-run
  localparam int ACR_T1_FREE_BIT = 6;
  // IER write bit: 1 sets, 0 clears
  localparam int IER_SET_BIT = 7;

  localparam logic [7:0]       PORT_B_HELD = 8'h08;
  localparam logic [TMR_W-1:0] TMR_STOPPED = 16'hFFFF;

  typedef struct packed {
    act_t       action;
    reg_idx_t   register_index;
    logic [7:0] write_data;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq;
  } rsp_t;

  // Timer controls from the register file
  typedef struct packed {
    logic             load;
    logic             step;
    logic             reload_en;
    logic [TMR_W-1:0] load_value;
    logic [TMR_W-1:0] reload_value;
  } tmr_ctl_t;

endpackage

>>> design/vtir_if.sv
// ----------------------------------------------------------------------------
// vtir_in_if / vtir_out_if
// Valid/ready channels for bus requests and results.
// ----------------------------------------------------------------------------
interface vtir_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [3:0] register_index;
  logic [7:0] write_data;

  modport source (output valid, action, register_index, write_data, input ready);
  modport sink   (input valid, action, register_index, write_data, output ready);
endinterface

interface vtir_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       irq;

  modport source (output valid, read_data, irq, input ready);
  modport sink   (input valid, read_data, irq, output ready);
endinterface

>>> design/vtir_timer.sv
// ----------------------------------------------------------------------------
// vtir_timer
// 16-bit down timer with start, stop-at-0xFFFF and optional reload.
// ----------------------------------------------------------------------------
module vtir_timer (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  vtir_pkg::tmr_ctl_t                   ctl,
  output logic [vtir_pkg::TMR_W-1:0]           count,
  output logic                                 expire
);
  import vtir_pkg::*;

  logic [TMR_W-1:0] count_r, count_nxt;
  logic             active_r, active_nxt;

  // Next count / run state
  always_comb begin
    count_nxt  = count_r;
    active_nxt = active_r;
    expire     = 1'b0;
    if (ctl.load) begin
      count_nxt  = ctl.load_value;
      active_nxt = 1'b1;
    end else if (ctl.step && active_r) begin
      if (count_r == '0) begin
        expire = 1'b1;
        if (ctl.reload_en) begin
          count_nxt = ctl.reload_value;
        end else begin
          active_nxt = 1'b0;
          count_nxt  = TMR_STOPPED;
        end
      end else begin
        count_nxt = count_r - TMR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      active_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      active_r <= active_nxt;
    end
  end

  assign count = count_r;

  // A stopped timer keeps its count unless loaded
  a_stopped_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !active_r && !ctl.load |=> $stable(count_r))
    else $error("stopped timer changed count");

  // Expiry only from zero
  a_expire_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
    expire |-> (count_r == '0) && active_r)
    else $error("timer expired from nonzero count");

  // Expiry without reload stops the timer at 0xFFFF
  a_expire_stop: assert property (@(posedge clk) disable iff (!rst_n)
    expire && !ctl.reload_en |=> !active_r && (count_r == TMR_STOPPED))
    else $error("timer did not stop after expiry");

endmodule

>>> design/vtir_regs.sv
// ----------------------------------------------------------------------------
// vtir_regs
// Register file: ports, latches, shift byte, controls, interrupt logic,
// tick prescaler and the two timers. Applies one request when en is high.
// ----------------------------------------------------------------------------
module vtir_regs #(
  parameter int TICK_DIVIDE = vtir_pkg::TICK_DIVIDE_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  vtir_pkg::req_t req,
  output vtir_pkg::rsp_t rsp
);
  import vtir_pkg::*;

  localparam int PW = (TICK_DIVIDE > 1) ? $clog2(TICK_DIVIDE) : 1;
  localparam logic [PW-1:0] PRE_LAST = PW'(TICK_DIVIDE - 1);

  logic [7:0]        pb_out_r, pb_out_nxt;
  logic [7:0]        pa_out_r, pa_out_nxt;
  logic [7:0]        pb_dir_r, pb_dir_nxt;
  logic [7:0]        pa_dir_r, pa_dir_nxt;
  logic [TMR_W-1:0]  t1_latch_r, t1_latch_nxt;
  logic [7:0]        t2_lo_latch_r, t2_lo_latch_nxt;
  logic [7:0]        sr_r, sr_nxt;
  logic [7:0]        acr_r, acr_nxt;
  logic [7:0]        pcr_r, pcr_nxt;
  logic [FLAG_W-1:0] flags_r, flags_nxt;
  logic [FLAG_W-1:0] ien_r, ien_nxt;
  logic [PW-1:0]     pre_r, pre_nxt;

  logic             is_rd, is_wr, is_tick, pre_wrap;
  logic [TMR_W-1:0] t1_count, t2_count;
  logic             t1_expire, t2_expire;
  tmr_ctl_t         t1_ctl, t2_ctl;
  logic             irq_now;
  logic [7:0]       rd_data;

  assign is_rd   = en && (req.action == ACT_READ);
  assign is_wr   = en && (req.action == ACT_WRITE);
  assign is_tick = en && (req.action == ACT_TICK);
  assign pre_wrap = (pre_r == PRE_LAST);

  // Prescaler
  always_comb begin
    pre_nxt = pre_r;
    if (is_tick) begin
      pre_nxt = pre_wrap ? '0 : pre_r + PW'(1);
    end
  end

  // Timer controls
  always_comb begin
    t1_ctl.load         = is_wr && (req.register_index == REG_T1CH);
    t1_ctl.step         = is_tick && pre_wrap;
    t1_ctl.reload_en    = acr_r[ACR_T1_FREE_BIT];
    t1_ctl.load_value   = {req.write_data, t1_latch_r[7:0]};
    t1_ctl.reload_value = t1_latch_r;
    t2_ctl.load         = is_wr && (req.register_index == REG_T2CH);
    t2_ctl.step         = is_tick && pre_wrap;
    t2_ctl.reload_en    = 1'b0;
    t2_ctl.load_value   = {req.write_data, t2_lo_latch_r};
    t2_ctl.reload_value = TMR_STOPPED;
  end

  vtir_timer u_t1 (.clk, .rst_n, .ctl(t1_ctl), .count(t1_count), .expire(t1_expire));
  vtir_timer u_t2 (.clk, .rst_n, .ctl(t2_ctl), .count(t2_count), .expire(t2_expire));

  assign irq_now = |(flags_r & ien_r);

  // Read mux on current state
  always_comb begin
    case (req.register_index)
      REG_ORB:            rd_data = pb_out_r;
      REG_ORA, REG_ORA_NH: rd_data = pa_out_r;
      REG_DDRB:           rd_data = pb_dir_r;
      REG_DDRA:           rd_data = pa_dir_r;
      REG_T1CL:           rd_data = t1_count[7:0];
      REG_T1CH:           rd_data = t1_count[15:8];
      REG_T1LL:           rd_data = t1_latch_r[7:0];
      REG_T1LH:           rd_data = t1_latch_r[15:8];
      REG_T2CL:           rd_data = t2_count[7:0];
      REG_T2CH:           rd_data = t2_count[15:8];
      REG_SR:             rd_data = sr_r;
      REG_ACR:            rd_data = acr_r;
      REG_PCR:            rd_data = pcr_r;
      REG_IFR:            rd_data = {irq_now, flags_r};
      REG_IER:            rd_data = {1'b1, ien_r};
      default:            rd_data = '0;
    endcase
  end

  // Register writes, read side effects and flag sets
  always_comb begin
    pb_out_nxt      = pb_out_r;
    pa_out_nxt      = pa_out_r;
    pb_dir_nxt      = pb_dir_r;
    pa_dir_nxt      = pa_dir_r;
    t1_latch_nxt    = t1_latch_r;
    t2_lo_latch_nxt = t2_lo_latch_r;
    sr_nxt          = sr_r;
    acr_nxt         = acr_r;
    pcr_nxt         = pcr_r;
    flags_nxt       = flags_r;
    ien_nxt         = ien_r;
    if (is_rd) begin
      case (req.register_index)
        REG_T1CL: flags_nxt[FLAG_T1_BIT] = 1'b0;
        REG_T2CL: flags_nxt[FLAG_T2_BIT] = 1'b0;
        REG_SR:   flags_nxt[FLAG_SR_BIT] = 1'b0;
        default:  ;
      endcase
    end
    if (is_wr) begin
      case (req.register_index)
        REG_ORB: pb_out_nxt = (pb_out_r & ~pb_dir_r) | (req.write_data & pb_dir_r)
                              | PORT_B_HELD;
        REG_ORA, REG_ORA_NH: pa_out_nxt = req.write_data;
        REG_DDRB: pb_dir_nxt = req.write_data;
        REG_DDRA: pa_dir_nxt = req.write_data;
        REG_T1CL, REG_T1LL: t1_latch_nxt[7:0] = req.write_data;
        REG_T1LH: t1_latch_nxt[15:8] = req.write_data;
        REG_T1CH: begin
          t1_latch_nxt[15:8]     = req.write_data;
          flags_nxt[FLAG_T1_BIT] = 1'b0;
        end
        REG_T2CL: t2_lo_latch_nxt = req.write_data;
        REG_T2CH: flags_nxt[FLAG_T2_BIT] = 1'b0;
        REG_SR: begin
          sr_nxt                 = req.write_data;
          flags_nxt[FLAG_SR_BIT] = 1'b0;
        end
        REG_ACR: acr_nxt = req.write_data;
        REG_PCR: pcr_nxt = req.write_data;
        REG_IFR: flags_nxt = flags_r & ~req.write_data[FLAG_W-1:0];
        REG_IER: begin
          if (req.write_data[IER_SET_BIT]) begin
            ien_nxt = ien_r | req.write_data[FLAG_W-1:0];
          end else begin
            ien_nxt = ien_r & ~req.write_data[FLAG_W-1:0];
          end
        end
        default: ;
      endcase
    end
    if (t1_expire) flags_nxt[FLAG_T1_BIT] = 1'b1;
    if (t2_expire) flags_nxt[FLAG_T2_BIT] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pb_out_r      <= PORT_B_HELD;
      pa_out_r      <= '0;
      pb_dir_r      <= '0;
      pa_dir_r      <= '0;
      t1_latch_r    <= '0;
      t2_lo_latch_r <= '0;
      sr_r          <= '0;
      acr_r         <= '0;
      pcr_r         <= '0;
      flags_r       <= '0;
      ien_r         <= '0;
      pre_r         <= '0;
    end else begin
      pb_out_r      <= pb_out_nxt;
      pa_out_r      <= pa_out_nxt;
      pb_dir_r      <= pb_dir_nxt;
      pa_dir_r      <= pa_dir_nxt;
      t1_latch_r    <= t1_latch_nxt;
      t2_lo_latch_r <= t2_lo_latch_nxt;
      sr_r          <= sr_nxt;
      acr_r         <= acr_nxt;
      pcr_r         <= pcr_nxt;
      flags_r       <= flags_nxt;
      ien_r         <= ien_nxt;
      pre_r         <= pre_nxt;
    end
  end

  // Result: read data only on reads, irq after the update
  assign rsp.read_data = is_rd ? rd_data : '0;
  assign rsp.irq       = |(flags_nxt & ien_nxt);

  // Prescaler stays below the divide ratio
  a_pre_range: assert property (@(posedge clk) disable iff (!rst_n)
    pre_r <= PRE_LAST)
    else $error("prescaler out of range");

  // Port B bit 3 is always held high
  a_pb_held: assert property (@(posedge clk) disable iff (!rst_n)
    pb_out_r[3])
    else $error("port B held bit dropped");

  // Flags change only on an applied request
  a_flags_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(flags_r))
    else $error("flags changed without a request");

endmodule

>>> design/via_timer_interrupt_registers.sv
// ----------------------------------------------------------------------------
// via_timer_interrupt_registers
// Timer and interrupt register subset of a versatile interface adapter.
// Path: from request accept to result valid through the input register, then
//   the result register.
// Throughput: one request per cycle while the output channel is not stalled.
// Reset (rst_n low, synchronous): channels empty, port B output 0x08, all
//   other registers, timers, flags, enables and prescaler zero.
// ----------------------------------------------------------------------------
module via_timer_interrupt_registers #(
  parameter int TICK_DIVIDE = vtir_pkg::TICK_DIVIDE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  vtir_in_if.sink     in_ch,
  vtir_out_if.source  out_ch
);
  import vtir_pkg::*;

  logic in_vld_r;
  req_t in_req_r;
  logic out_vld_r;
  rsp_t out_rsp_r;
  logic advance;
  rsp_t rsp;

  // Apply the held request when the result register can take it
  assign advance     = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_req_r.action         <= in_ch.action;
      in_req_r.register_index <= in_ch.register_index;
      in_req_r.write_data     <= in_ch.write_data;
    end
  end

  vtir_regs #(.TICK_DIVIDE(TICK_DIVIDE)) u_regs (
    .clk,
    .rst_n,
    .en  (advance),
    .req (in_req_r),
    .rsp (rsp)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_rsp_r <= rsp;
    end
  end

  assign out_ch.valid     = out_vld_r;
  assign out_ch.read_data = out_rsp_r.read_data;
  assign out_ch.irq       = out_rsp_r.irq;

  // An empty input register always takes a request
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_vld_r |-> in_ch.ready)
    else $error("input stalled while empty");

  // An applied request always yields a result
  a_adv_result: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_vld_r)
    else $error("result lost");

  // Non-read requests return zero read data
  a_nonread_zero: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (in_req_r.action != ACT_READ) |=> out_rsp_r.read_data == '0)
    else $error("nonzero read data on a non-read");

  // A held request is not dropped
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !advance |=> in_vld_r && $stable(in_req_r))
    else $error("pending request lost");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the VIA timer and interrupt register block. A driver
// feeds bus reads, writes and clock ticks from a queue; a shadow copy of the
// adapter registers predicts read data and the interrupt line for every
// accepted request, and a monitor checks each result in order. The run covers
// directed corner cases and then random timer, interrupt and port sequences
// with several idle/stall mixes, including a long output back-pressure stretch.
// ----------------------------------------------------------------------------
module tb_top;
  import vtir_pkg::*;

  localparam int   TICK_DIV      = TICK_DIVIDE_DEF;
  localparam int   PHASE_ITEMS   = 450;
  localparam int   DRAIN_CYCLES  = 10;
  localparam int   LONG_HOLD     = 300;
  localparam int   CYCLE_LIMIT   = 400000;
  localparam int   MAX_PRINTS    = 40;
  localparam act_t ACT_NONE      = 2'd3;

  // Shadow copy of the adapter registers
  typedef struct {
    logic [7:0]        orb;
    logic [7:0]        ora;
    logic [7:0]        ddrb;
    logic [7:0]        ddra;
    logic [TMR_W-1:0]  t1_latch;
    logic [TMR_W-1:0]  t1_count;
    logic              t1_run;
    logic [7:0]        t2_low;
    logic [TMR_W-1:0]  t2_count;
    logic              t2_run;
    logic [7:0]        sr;
    logic [7:0]        acr;
    logic [7:0]        pcr;
    logic [FLAG_W-1:0] ifr;
    logic [FLAG_W-1:0] ier;
    int unsigned       prescale;
  } via_shadow_t;

  logic clk;
  logic rst_n;

  vtir_in_if  in_ch ();
  vtir_out_if out_ch ();

  via_timer_interrupt_registers #(
    .TICK_DIVIDE(TICK_DIV)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  via_shadow_t shadow;
  req_t        pending_reqs[$];
  rsp_t        expected_results[$];
  req_t        offered_req;
  int          send_gap_pct;
  int          stall_pct;
  logic        long_hold_on;
  int          hold_cycles;
  int          error_count;
  int          result_count;
  int          cycle_count;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mismatch reporting: one line each, printing capped
  task automatic report_mismatch(input string msg);
    if (error_count < MAX_PRINTS)
      $display("[%0t] mismatch: %s", $time, msg);
    error_count++;
  endtask

  // Predictor: applies one request to the shadow and returns its result
  function automatic rsp_t via_predict(input req_t rq);
    rsp_t       res;
    logic [7:0] rd;
    logic [7:0] v;
    rd = 8'h00;
    v  = rq.write_data;
    case (rq.action)
      ACT_READ: begin
        case (rq.register_index)
          REG_ORB:             rd = shadow.orb;
          REG_ORA, REG_ORA_NH: rd = shadow.ora;
          REG_DDRB:            rd = shadow.ddrb;
          REG_DDRA:            rd = shadow.ddra;
          REG_T1CL: begin
            rd = shadow.t1_count[7:0];
            shadow.ifr[FLAG_T1_BIT] = 1'b0;
          end
          REG_T1CH:            rd = shadow.t1_count[15:8];
          REG_T1LL:            rd = shadow.t1_latch[7:0];
          REG_T1LH:            rd = shadow.t1_latch[15:8];
          REG_T2CL: begin
            rd = shadow.t2_count[7:0];
            shadow.ifr[FLAG_T2_BIT] = 1'b0;
          end
          REG_T2CH:            rd = shadow.t2_count[15:8];
          REG_SR: begin
            rd = shadow.sr;
            shadow.ifr[FLAG_SR_BIT] = 1'b0;
          end
          REG_ACR:             rd = shadow.acr;
          REG_PCR:             rd = shadow.pcr;
          REG_IFR:             rd = {|(shadow.ifr & shadow.ier), shadow.ifr};
          default:             rd = {1'b1, shadow.ier};
        endcase
      end
      ACT_WRITE: begin
        case (rq.register_index)
          REG_ORB:
            shadow.orb = (shadow.orb & ~shadow.ddrb) | (v & shadow.ddrb) | PORT_B_HELD;
          REG_ORA, REG_ORA_NH: shadow.ora = v;
          REG_DDRB:            shadow.ddrb = v;
          REG_DDRA:            shadow.ddra = v;
          REG_T1CL, REG_T1LL:  shadow.t1_latch[7:0] = v;
          REG_T1LH:            shadow.t1_latch[15:8] = v;
          REG_T1CH: begin
            shadow.t1_latch[15:8] = v;
            shadow.t1_count = shadow.t1_latch;
            shadow.t1_run = 1'b1;
            shadow.ifr[FLAG_T1_BIT] = 1'b0;
          end
          REG_T2CL:            shadow.t2_low = v;
          REG_T2CH: begin
            shadow.t2_count = {v, shadow.t2_low};
            shadow.t2_run = 1'b1;
            shadow.ifr[FLAG_T2_BIT] = 1'b0;
          end
          REG_SR: begin
            shadow.sr = v;
            shadow.ifr[FLAG_SR_BIT] = 1'b0;
          end
          REG_ACR:             shadow.acr = v;
          REG_PCR:             shadow.pcr = v;
          REG_IFR:             shadow.ifr = shadow.ifr & ~v[FLAG_W-1:0];
          default: begin
            if (v[IER_SET_BIT]) shadow.ier = shadow.ier | v[FLAG_W-1:0];
            else                shadow.ier = shadow.ier & ~v[FLAG_W-1:0];
          end
        endcase
      end
      ACT_TICK: begin
        shadow.prescale++;
        if (shadow.prescale >= TICK_DIV) begin
          shadow.prescale = 0;
          if (shadow.t1_run) begin
            if (shadow.t1_count == '0) begin
              shadow.ifr[FLAG_T1_BIT] = 1'b1;
              if (shadow.acr[ACR_T1_FREE_BIT]) begin
                shadow.t1_count = shadow.t1_latch;
              end else begin
                shadow.t1_run = 1'b0;
                shadow.t1_count = TMR_STOPPED;
              end
            end else begin
              shadow.t1_count = shadow.t1_count - 1'b1;
            end
          end
          if (shadow.t2_run) begin
            if (shadow.t2_count == '0) begin
              shadow.ifr[FLAG_T2_BIT] = 1'b1;
              shadow.t2_run = 1'b0;
              shadow.t2_count = TMR_STOPPED;
            end else begin
              shadow.t2_count = shadow.t2_count - 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    res.read_data = rd;
    res.irq = |(shadow.ifr & shadow.ier);
    return res;
  endfunction

  // Stimulus helpers
  task automatic add_req(input act_t a, input reg_idx_t r, input logic [7:0] d);
    req_t rq;
    rq.action = a;
    rq.register_index = r;
    rq.write_data = d;
    pending_reqs.insert(pending_reqs.size(), rq);
  endtask

  // Timer load values: mostly tiny so the timers expire often
  function automatic logic [7:0] short_count();
    if ($urandom_range(0, 7) == 0) return 8'($urandom);
    return 8'($urandom_range(0, 3));
  endfunction

  function automatic reg_idx_t watch_reg();
    case ($urandom_range(0, 5))
      0:       return REG_IFR;
      1:       return REG_T1CL;
      2:       return REG_T1CH;
      3:       return REG_T2CL;
      4:       return REG_T2CH;
      default: return REG_IER;
    endcase
  endfunction

  // Run of ticks, with reads of timer/interrupt registers mixed in
  task automatic run_ticks(input int n, input int read_pct);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < read_pct)
        add_req(ACT_READ, watch_reg(), 8'($urandom));
      add_req(ACT_TICK, reg_idx_t'($urandom), 8'($urandom));
    end
  endtask

  task automatic queue_random_sequence();
    logic [7:0] en;
    en = 8'($urandom);
    case ($urandom_range(0, 9))
      // timer 1 load and run
      0, 1: begin
        if ($urandom_range(0, 1)) add_req(ACT_WRITE, REG_ACR, 8'($urandom));
        if ($urandom_range(0, 2) == 0) begin
          en[FLAG_T1_BIT] = 1'b1;
          add_req(ACT_WRITE, REG_IER, en);
        end
        add_req(ACT_WRITE, $urandom_range(0, 1) ? REG_T1LL : REG_T1CL, short_count());
        if ($urandom_range(0, 5) == 0) add_req(ACT_WRITE, REG_T1LH, 8'($urandom));
        add_req(ACT_WRITE, REG_T1CH,
                ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'h00);
        run_ticks($urandom_range(4, 48), 20);
      end
      // timer 2 load and run
      2: begin
        if ($urandom_range(0, 2) == 0) begin
          en[FLAG_T2_BIT] = 1'b1;
          add_req(ACT_WRITE, REG_IER, en);
        end
        add_req(ACT_WRITE, REG_T2CL, short_count());
        add_req(ACT_WRITE, REG_T2CH,
                ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'h00);
        run_ticks($urandom_range(4, 48), 20);
      end
      // interrupt enable and flag manipulation
      3: begin
        add_req(ACT_WRITE, REG_IER, en);
        add_req(ACT_READ, REG_IFR, 8'($urandom));
        add_req(ACT_WRITE, REG_IFR, 8'($urandom));
        add_req(ACT_READ, REG_IER, 8'($urandom));
      end
      // port B with direction mask
      4: begin
        add_req(ACT_WRITE, REG_DDRB, 8'($urandom));
        add_req(ACT_WRITE, REG_ORB, 8'($urandom));
        add_req(ACT_READ, REG_ORB, 8'($urandom));
      end
      // shift register
      5: begin
        add_req(ACT_WRITE, REG_SR, 8'($urandom));
        add_req(ACT_READ, REG_SR, 8'($urandom));
        add_req(ACT_READ, REG_IFR, 8'($urandom));
      end
      // any register, write then read back
      6: begin
        reg_idx_t r;
        r = reg_idx_t'($urandom);
        add_req(ACT_WRITE, r, 8'($urandom));
        add_req(ACT_READ, r, 8'($urandom));
      end
      7: run_ticks($urandom_range(1, 20), 0);
      // noise, including the unused action
      default: begin
        repeat ($urandom_range(1, 6))
          add_req(act_t'($urandom_range(0, 3)), reg_idx_t'($urandom), 8'($urandom));
      end
    endcase
  endtask

  // Wait until every request is sent and every result has arrived
  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_ch.valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Driver: offers queued requests, predicts on accept
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        expected_results.insert(expected_results.size(), via_predict(offered_req));
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
          offered_req = pending_reqs.pop_front();
          in_ch.valid          <= 1'b1;
          in_ch.action         <= offered_req.action;
          in_ch.register_index <= offered_req.register_index;
          in_ch.write_data     <= offered_req.write_data;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result against the oldest prediction
  always @(posedge clk) begin : result_monitor
    rsp_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result rd=%02h irq=%0b",
                                    out_ch.read_data, out_ch.irq));
        end else begin
          want = expected_results.pop_front();
          if (out_ch.read_data !== want.read_data)
            report_mismatch($sformatf("result %0d read_data %02h, want %02h",
                                      result_count, out_ch.read_data, want.read_data));
          if (out_ch.irq !== want.irq)
            report_mismatch($sformatf("result %0d irq %0b, want %0b",
                                      result_count, out_ch.irq, want.irq));
        end
        result_count++;
      end
      out_ch.ready <= !(long_hold_on || $urandom_range(0, 99) < stall_pct);
    end
  end

  // Length of the long output hold-off
  always @(posedge clk) begin
    if (long_hold_on) hold_cycles <= hold_cycles + 1;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // Stimulus and phase control
  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_READ;
    in_ch.register_index = REG_ORB;
    in_ch.write_data = 8'h00;
    out_ch.ready = 1'b0;
    send_gap_pct = 0;
    stall_pct = 0;
    long_hold_on = 1'b0;
    hold_cycles = 0;
    error_count = 0;
    result_count = 0;
    cycle_count = 0;

    shadow = '{orb: PORT_B_HELD, default: '0};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: reset values, port B hold bit, both timers expiring together
    // with timer 1 free-running, flag clears on read, unused action
    add_req(ACT_READ, REG_ORB, 8'h00);
    add_req(ACT_READ, REG_IER, 8'hFF);
    add_req(ACT_WRITE, REG_DDRB, 8'hFF);
    add_req(ACT_WRITE, REG_ORB, 8'h00);
    add_req(ACT_READ, REG_ORB, 8'h00);
    add_req(ACT_WRITE, REG_IER, 8'hFF);
    add_req(ACT_WRITE, REG_ACR, 8'h40);
    add_req(ACT_WRITE, REG_T1LL, 8'h00);
    add_req(ACT_WRITE, REG_T1CH, 8'h00);
    add_req(ACT_WRITE, REG_T2CL, 8'h00);
    add_req(ACT_WRITE, REG_T2CH, 8'h00);
    run_ticks(TICK_DIV, 0);
    add_req(ACT_READ, REG_IFR, 8'h00);
    add_req(ACT_READ, REG_T1CL, 8'hFF);
    add_req(ACT_READ, REG_T2CH, 8'h00);
    add_req(ACT_WRITE, REG_SR, 8'hFF);
    add_req(ACT_READ, REG_SR, 8'hFF);
    add_req(ACT_WRITE, REG_IFR, 8'h7F);
    add_req(ACT_WRITE, REG_IER, 8'h7F);
    add_req(ACT_NONE, REG_ORA_NH, 8'hFF);
    add_req(ACT_READ, REG_IER, 8'h00);
    wait_drained();

    // No idling, with one long output hold-off while requests keep coming
    long_hold_on <= 1'b1;
    while (pending_reqs.size() < PHASE_ITEMS) queue_random_sequence();
    while (hold_cycles < LONG_HOLD) @(negedge clk);
    long_hold_on <= 1'b0;
    wait_drained();

    // Sender idles often
    send_gap_pct = 47;
    while (pending_reqs.size() < PHASE_ITEMS) queue_random_sequence();
    wait_drained();

    // Receiver stalls often
    send_gap_pct = 0;
    stall_pct = 47;
    while (pending_reqs.size() < PHASE_ITEMS) queue_random_sequence();
    wait_drained();

    // Both sides idle now and then
    send_gap_pct = 11;
    stall_pct = 11;
    while (pending_reqs.size() < PHASE_ITEMS) queue_random_sequence();
    wait_drained();

    if (error_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
